### design/tfn_pkg.sv
// Package: widths and shared constants of the triangle face normal block.
`default_nettype none
package tfn_pkg;
   localparam int COORD_BITS_DEF = 16;
   localparam int FIELD_BITS     = 16;
   localparam int NORM_BITS      = 16;
   localparam int NORM_LO_BIT    = 29;
   localparam int NORM_ONE_SHIFT = 14;
   localparam int MAG_BITS       = NORM_LO_BIT + 1;
   localparam int SUMSQ_BITS     = 2 * MAG_BITS + 2;
   localparam int ROOT_BITS      = SUMSQ_BITS / 2;
   localparam int QUOT_BITS      = NORM_ONE_SHIFT + 1;

   typedef struct packed {
      logic [FIELD_BITS-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
      logic [FIELD_BITS-1:0] vertex_index_a, vertex_index_b, vertex_index_c;
   } req_type;

   typedef struct packed {
      logic signed [NORM_BITS-1:0] normal_x, normal_y, normal_z;
      logic                        degenerate;
      logic [FIELD_BITS-1:0]       out_index_a, out_index_b, out_index_c;
   } rsp_type;
endpackage
`default_nettype wire

### design/tfn_if.sv
// Interfaces: valid/ready channels for triangles and normals.
`default_nettype none
interface tfn_req_if;
   logic             valid;
   logic             ready;
   tfn_pkg::req_type req;
   modport source (output valid, output req, input ready);
   modport sink   (input valid, input req, output ready);
endinterface

interface tfn_rsp_if;
   logic             valid;
   logic             ready;
   tfn_pkg::rsp_type rsp;
   modport source (output valid, output rsp, input ready);
   modport sink   (input valid, input rsp, output ready);
endinterface
`default_nettype wire

### design/triangle_face_normal_top.sv
// Top level: pipelined unit face normal of one triangle per cycle.
//
// Usage
//   req_chan (sink): one triangle per transfer, vertices A, B, C in signed
//   Q7.8 (low COORD_BITS of each field used) plus three vertex indices.
//   rsp_chan (source): one transfer per triangle, normal in signed Q1.14,
//   degenerate flag (zero cross product, zero normal), indices unchanged.
// Throughput: one triangle per cycle; a new triangle is taken every cycle
//   while the output is being drained.
// Pipeline: 6 + 1 + 31 + 1 + 15 + 1 = 55 register stages, set by the
//   31-step bit-serial square root (one root bit per stage) and the
//   15-step restoring divide, each step one register stage, plus edge,
//   product, cross, normalize, shift, square, root setup, divide setup
//   and output stages.
// Stall: the whole pipeline advances only when the output register is
//   empty or being taken; req ready follows that, so no item is lost or
//   repeated.  Reset (synchronous, active high) clears every valid bit;
//   data registers are not reset.
// The results come out in request order.
`default_nettype none
module triangle_face_normal_top #(
   parameter int COORD_BITS = tfn_pkg::COORD_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   tfn_req_if.sink   req_chan,
   tfn_rsp_if.source rsp_chan
);
   localparam int EB  = COORD_BITS + 1;          // edge width
   localparam int CB  = 2 * EB + 1;              // cross product width
   localparam int MB  = tfn_pkg::MAG_BITS;
   localparam int SB  = tfn_pkg::SUMSQ_BITS;
   localparam int RB  = tfn_pkg::ROOT_BITS;
   localparam int QB  = tfn_pkg::QUOT_BITS;
   localparam int FB  = tfn_pkg::FIELD_BITS;
   localparam int NB  = tfn_pkg::NORM_BITS;
   localparam int CMB = CB;                      // magnitude bits
   localparam int SHB = $clog2(CMB + MB + 1);
   localparam int NUMB = MB + QB + 1;            // dividend width
   localparam int DENB = RB + 1;                 // divisor width

   // global advance
   logic adv;
   logic out_vld_ff;
   assign adv = !out_vld_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   // ---------------- stage 1: edges
   logic                 s1_vld_ff;
   logic signed [EB-1:0] ux_ff, uy_ff, uz_ff, vx_ff, vy_ff, vz_ff;
   logic [3*FB-1:0]      idx1_ff;

   // field zero-extended first so any COORD_BITS selects in range
   function automatic logic signed [EB-1:0] crd(input logic [FB-1:0] r);
      logic [FB+COORD_BITS-1:0]     rx;
      logic signed [COORD_BITS-1:0] c;
      rx = {{COORD_BITS{1'b0}}, r};
      c  = rx[COORD_BITS-1:0];
      return EB'(c);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) s1_vld_ff <= 1'b0;
      else if (adv) s1_vld_ff <= req_chan.valid;
      if (adv) begin
         ux_ff <= crd(req_chan.req.bx) - crd(req_chan.req.ax);
         uy_ff <= crd(req_chan.req.by) - crd(req_chan.req.ay);
         uz_ff <= crd(req_chan.req.bz) - crd(req_chan.req.az);
         vx_ff <= crd(req_chan.req.cx) - crd(req_chan.req.ax);
         vy_ff <= crd(req_chan.req.cy) - crd(req_chan.req.ay);
         vz_ff <= crd(req_chan.req.cz) - crd(req_chan.req.az);
         idx1_ff <= {req_chan.req.vertex_index_a, req_chan.req.vertex_index_b,
                     req_chan.req.vertex_index_c};
      end
   end

   // ---------------- stage 2: products
   logic                   s2_vld_ff;
   logic signed [CB-2:0]   p_ff [6];
   logic [3*FB-1:0]        idx2_ff;
   always_ff @(posedge clock) begin
      if (reset) s2_vld_ff <= 1'b0;
      else if (adv) s2_vld_ff <= s1_vld_ff;
      if (adv) begin
         p_ff[0] <= uy_ff * vz_ff;  p_ff[1] <= uz_ff * vy_ff;
         p_ff[2] <= uz_ff * vx_ff;  p_ff[3] <= ux_ff * vz_ff;
         p_ff[4] <= ux_ff * vy_ff;  p_ff[5] <= uy_ff * vx_ff;
         idx2_ff <= idx1_ff;
      end
   end

   // ---------------- stage 3: cross, sign, magnitude, max
   logic                 s3_vld_ff;
   logic [CMB-1:0]       mag3_ff [3];
   logic [2:0]           neg3_ff;
   logic [CMB-1:0]       max3_ff;
   logic [3*FB-1:0]      idx3_ff;
   logic signed [CB-1:0] w_in [3];
   logic [CMB-1:0]       mag_in [3];
   logic [CMB-1:0]       mx_in;
   always_comb begin
      w_in[0] = CB'(p_ff[0]) - CB'(p_ff[1]);
      w_in[1] = CB'(p_ff[2]) - CB'(p_ff[3]);
      w_in[2] = CB'(p_ff[4]) - CB'(p_ff[5]);
      mx_in = '0;
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = w_in[i][CB-1] ? CMB'(-w_in[i]) : CMB'(w_in[i]);
         if (mag_in[i] > mx_in) mx_in = mag_in[i];
      end
   end
   always_ff @(posedge clock) begin
      if (reset) s3_vld_ff <= 1'b0;
      else if (adv) s3_vld_ff <= s2_vld_ff;
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            mag3_ff[i] <= mag_in[i];
            neg3_ff[i] <= w_in[i][CB-1];
         end
         max3_ff <= mx_in;
         idx3_ff <= idx2_ff;
      end
   end

   // ---------------- stage 4: leading one -> normalize shift
   localparam int TOTB = CMB + MB;
   logic                 s4_vld_ff;
   logic [TOTB-1:0]      mag4_ff [3];
   logic [2:0]           neg4_ff;
   logic                 deg4_ff;
   logic [SHB-1:0]       lead4_ff;
   logic [3*FB-1:0]      idx4_ff;
   logic [SHB-1:0]       lead_in;
   always_comb begin
      lead_in = '0;
      for (int b = 0; b < CMB; b++)
         if (max3_ff[b]) lead_in = SHB'(b);
   end
   always_ff @(posedge clock) begin
      if (reset) s4_vld_ff <= 1'b0;
      else if (adv) s4_vld_ff <= s3_vld_ff;
      if (adv) begin
         for (int i = 0; i < 3; i++)
            mag4_ff[i] <= {mag3_ff[i], {MB{1'b0}}};
         neg4_ff  <= neg3_ff;
         deg4_ff  <= (max3_ff == '0);
         lead4_ff <= lead_in;
         idx4_ff  <= idx3_ff;
      end
   end

   // ---------------- stage 5: shift to [2^29, 2^30)
   // Value pre-shifted left by MB; lead bit lands at MB-1 after right shift.
   logic            s5_vld_ff;
   logic [MB-1:0]   r5_ff [3];
   logic [2:0]      neg5_ff;
   logic            deg5_ff;
   logic [3*FB-1:0] idx5_ff;
   logic [TOTB-1:0] sh_tmp [3];
   always_comb begin
      for (int i = 0; i < 3; i++)
         sh_tmp[i] = mag4_ff[i] >> (lead4_ff + SHB'(1));
   end
   always_ff @(posedge clock) begin
      if (reset) s5_vld_ff <= 1'b0;
      else if (adv) s5_vld_ff <= s4_vld_ff;
      if (adv) begin
         for (int i = 0; i < 3; i++) r5_ff[i] <= sh_tmp[i][MB-1:0];
         neg5_ff <= neg4_ff;
         deg5_ff <= deg4_ff;
         idx5_ff <= idx4_ff;
      end
   end

   // ---------------- stage 6: squares (one multiplier per lane)
   logic            s6_vld_ff;
   logic [2*MB-1:0] sq6_ff [3];
   logic [MB-1:0]   r6_ff [3];
   logic [2:0]      neg6_ff;
   logic            deg6_ff;
   logic [3*FB-1:0] idx6_ff;
   always_ff @(posedge clock) begin
      if (reset) s6_vld_ff <= 1'b0;
      else if (adv) s6_vld_ff <= s5_vld_ff;
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            sq6_ff[i] <= r5_ff[i] * r5_ff[i];
            r6_ff[i]  <= r5_ff[i];
         end
         neg6_ff <= neg5_ff;
         deg6_ff <= deg5_ff;
         idx6_ff <= idx5_ff;
      end
   end

   // ---------------- square root: RB stages, one root bit each
   localparam int RS = RB;
   logic            q_vld_ff [RS+1];
   logic [SB-1:0]   rem_ff   [RS+1];
   logic [SB-1:0]   sx_ff    [RS+1];   // remaining radicand bits
   logic [RB-1:0]   root_ff  [RS+1];
   logic [MB-1:0]   rq_ff    [RS+1][3];
   logic [2:0]      nq_ff    [RS+1];
   logic            dq_ff    [RS+1];
   logic [3*FB-1:0] iq_ff    [RS+1];

   always_ff @(posedge clock) begin
      if (reset) q_vld_ff[0] <= 1'b0;
      else if (adv) q_vld_ff[0] <= s6_vld_ff;
      if (adv) begin
         rem_ff[0]  <= '0;
         sx_ff[0]   <= SB'(sq6_ff[0]) + SB'(sq6_ff[1]) + SB'(sq6_ff[2]);
         root_ff[0] <= '0;
         rq_ff[0]   <= r6_ff;
         nq_ff[0]   <= neg6_ff;
         dq_ff[0]   <= deg6_ff;
         iq_ff[0]   <= idx6_ff;
      end
   end

   for (genvar k = 0; k < RS; k++) begin : g_sqrt
      logic [SB-1:0] rem_sh, trial;
      always_comb begin
         rem_sh = {rem_ff[k][SB-3:0], sx_ff[k][SB-1:SB-2]};
         trial  = SB'({root_ff[k], 2'b01});
      end
      always_ff @(posedge clock) begin
         if (reset) q_vld_ff[k+1] <= 1'b0;
         else if (adv) q_vld_ff[k+1] <= q_vld_ff[k];
         if (adv) begin
            if (rem_sh >= trial) begin
               rem_ff[k+1]  <= rem_sh - trial;
               root_ff[k+1] <= {root_ff[k][RB-2:0], 1'b1};
            end else begin
               rem_ff[k+1]  <= rem_sh;
               root_ff[k+1] <= {root_ff[k][RB-2:0], 1'b0};
            end
            sx_ff[k+1] <= {sx_ff[k][SB-3:0], 2'b00};
            rq_ff[k+1] <= rq_ff[k];
            nq_ff[k+1] <= nq_ff[k];
            dq_ff[k+1] <= dq_ff[k];
            iq_ff[k+1] <= iq_ff[k];
         end
      end
   end

   // ---------------- divide: q = (r*2^15 + L) / (2L), QB quotient bits
   localparam int DS = QB;
   logic            d_vld_ff [DS+1];
   logic [NUMB-1:0] num_ff   [DS+1][3];
   logic [DENB-1:0] den_ff   [DS+1];
   logic [DENB:0]   drem_ff  [DS+1][3];
   logic [QB-1:0]   quo_ff   [DS+1][3];
   logic [2:0]      nd_ff    [DS+1];
   logic            dd_ff    [DS+1];
   logic [3*FB-1:0] id_ff    [DS+1];

   always_ff @(posedge clock) begin
      if (reset) d_vld_ff[0] <= 1'b0;
      else if (adv) d_vld_ff[0] <= q_vld_ff[RS];
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            num_ff[0][i]  <= NUMB'({rq_ff[RS][i], {QB{1'b0}}})
                             + NUMB'(root_ff[RS]);
            drem_ff[0][i] <= '0;
            quo_ff[0][i]  <= '0;
         end
         den_ff[0] <= {root_ff[RS], 1'b0};
         nd_ff[0]  <= nq_ff[RS];
         dd_ff[0]  <= dq_ff[RS];
         id_ff[0]  <= iq_ff[RS];
      end
   end

   // Quotient < 2^QB since r <= L, so upper NUMB-QB bits preload the remainder.
   for (genvar k = 0; k < DS; k++) begin : g_div
      logic [DENB:0] pr [3];
      always_comb begin
         for (int i = 0; i < 3; i++) begin
            if (k == 0)
               pr[i] = (DENB+1)'(num_ff[k][i] >> (QB - 1));
            else
               pr[i] = {drem_ff[k][i][DENB-1:0], num_ff[k][i][QB-1-k]};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) d_vld_ff[k+1] <= 1'b0;
         else if (adv) d_vld_ff[k+1] <= d_vld_ff[k];
         if (adv) begin
            for (int i = 0; i < 3; i++) begin
               if (pr[i] >= {1'b0, den_ff[k]}) begin
                  drem_ff[k+1][i] <= pr[i] - {1'b0, den_ff[k]};
                  quo_ff[k+1][i]  <= {quo_ff[k][i][QB-2:0], 1'b1};
               end else begin
                  drem_ff[k+1][i] <= pr[i];
                  quo_ff[k+1][i]  <= {quo_ff[k][i][QB-2:0], 1'b0};
               end
               num_ff[k+1][i] <= num_ff[k][i];
            end
            den_ff[k+1] <= den_ff[k];
            nd_ff[k+1]  <= nd_ff[k];
            dd_ff[k+1]  <= dd_ff[k];
            id_ff[k+1]  <= id_ff[k];
         end
      end
   end

   // ---------------- output register
   tfn_pkg::rsp_type out_ff, out_in;
   always_comb begin
      logic signed [NB-1:0] n [3];
      for (int i = 0; i < 3; i++) begin
         n[i] = NB'(quo_ff[DS][i]);
         if (dd_ff[DS])      n[i] = '0;
         else if (nd_ff[DS][i]) n[i] = -n[i];
      end
      out_in.normal_x    = n[0];
      out_in.normal_y    = n[1];
      out_in.normal_z    = n[2];
      out_in.degenerate  = dd_ff[DS];
      out_in.out_index_a = id_ff[DS][3*FB-1:2*FB];
      out_in.out_index_b = id_ff[DS][2*FB-1:FB];
      out_in.out_index_c = id_ff[DS][FB-1:0];
   end
   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else if (adv) out_vld_ff <= d_vld_ff[DS];
      if (adv) out_ff <= out_in;
   end
   assign rsp_chan.valid = out_vld_ff;
   assign rsp_chan.rsp   = out_ff;
endmodule
`default_nettype wire

### tb/tfn_normal_checker.sv
// Checker: predicts the unit face normal of each triangle and compares results.
`default_nettype none
module tfn_normal_checker #(
   parameter int COORD_BITS = tfn_pkg::COORD_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   tfn_req_if.sink   req_mon,
   tfn_rsp_if.sink   rsp_mon,
   output int        fail_count,
   output int        pending_count
);
   tfn_pkg::rsp_type normal_queue[$];

   function automatic longint coord_value(logic [tfn_pkg::FIELD_BITS-1:0] raw);
      logic [63:0] v;
      v = 64'(raw) & ((64'd1 << COORD_BITS) - 64'd1);
      if (v[COORD_BITS-1])
         return longint'(v) - longint'(64'd1 << COORD_BITS);
      return longint'(v);
   endfunction

   function automatic logic [63:0] root_floor(logic [63:0] x);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x   = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic tfn_pkg::rsp_type face_normal(tfn_pkg::req_type t);
      tfn_pkg::rsp_type r;
      longint      ux, uy, uz, vx, vy, vz;
      longint      w[3];
      logic [63:0] mag[3];
      logic        neg[3];
      logic [63:0] m, s2, len, q;
      longint      n;
      ux = coord_value(t.bx) - coord_value(t.ax);
      uy = coord_value(t.by) - coord_value(t.ay);
      uz = coord_value(t.bz) - coord_value(t.az);
      vx = coord_value(t.cx) - coord_value(t.ax);
      vy = coord_value(t.cy) - coord_value(t.ay);
      vz = coord_value(t.cz) - coord_value(t.az);
      w[0] = uy * vz - uz * vy;
      w[1] = uz * vx - ux * vz;
      w[2] = ux * vy - uy * vx;
      m = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = w[i] < 0;
         mag[i] = neg[i] ? 64'(-w[i]) : 64'(w[i]);
         if (mag[i] > m) m = mag[i];
      end
      r = '0;
      r.degenerate = (m == 0);
      if (m != 0) begin
         while (m < (64'd1 << tfn_pkg::NORM_LO_BIT)) begin
            m = m << 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
         end
         while (m >= (64'd1 << (tfn_pkg::NORM_LO_BIT + 1))) begin
            m = m >> 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
         end
         s2  = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
         len = root_floor(s2);
         for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << (tfn_pkg::NORM_ONE_SHIFT + 1)) + len) / (len << 1);
            n = neg[i] ? -longint'(q) : longint'(q);
            if (i == 0) r.normal_x = n[15:0];
            else if (i == 1) r.normal_y = n[15:0];
            else r.normal_z = n[15:0];
         end
      end
      r.out_index_a = t.vertex_index_a;
      r.out_index_b = t.vertex_index_b;
      r.out_index_c = t.vertex_index_c;
      return r;
   endfunction

   always @(posedge clock) begin
      tfn_pkg::rsp_type want;
      tfn_pkg::rsp_type got;
      if (reset) begin
         fail_count    <= 0;
         pending_count <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            normal_queue.push_back(face_normal(req_mon.req));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.rsp;
            if (normal_queue.size() == 0) begin
               $display("%0t: unexpected result %p", $realtime, got);
               fail_count <= fail_count + 1;
            end else begin
               want = normal_queue.pop_front();
               if (want !== got) begin
                  $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= normal_queue.size();
      end
   end
endmodule
`default_nettype wire

### tb/tb_triangle_face_normal_top.sv
// Testbench top: triangle stimulus, output back-pressure and the verdict.
`default_nettype none
module tb_triangle_face_normal_top;
   localparam int RANDOM_TRIANGLES = 1000;
   localparam int STALL_LIMIT      = 5000;  // 55-stage pipe plus long stalls
   localparam int DRAIN_CYCLES     = 60;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   idle_cycles;
   int   send_idle_pct;  // sender gap odds, percent
   int   recv_idle_pct;  // receiver stall odds, percent

   tfn_req_if req_chan();
   tfn_rsp_if rsp_chan();

   triangle_face_normal_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   tfn_normal_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan.sink),
      .rsp_mon       (rsp_chan.sink),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Receiver: ready changes on the falling edge only.
   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog: counts cycles with no transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // One transfer: optional random gap first, then hold valid until taken.
   task automatic send_triangle(tfn_pkg::req_type t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.req   <= t;
      req_chan.valid <= 1'b1;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_vertices(logic [15:0] a[3], logic [15:0] b[3], logic [15:0] c[3]);
      tfn_pkg::req_type t;
      t = {a[0], a[1], a[2], b[0], b[1], b[2], c[0], c[1], c[2],
           16'($urandom), 16'($urandom), 16'($urandom)};
      send_triangle(t);
   endtask

   function automatic logic [15:0] rand_coord(int spread);
      case ($urandom_range(3))
         0:       return 16'($urandom);
         1:       return 16'($signed($urandom_range(2 * spread)) - spread);
         2:       return $urandom_range(1) ? 16'h7fff : 16'h8000;
         default: return 16'($signed($urandom_range(2 * 2560)) - 2560);
      endcase
   endfunction

   task automatic quiesce();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
   endtask

   initial begin
      logic [15:0]      a[3], b[3], c[3];
      tfn_pkg::req_type t;
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.req   = '0;
      rsp_chan.ready = 1'b0;
      send_idle_pct  = 0;
      recv_idle_pct  = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: axis-aligned faces, extremes, degenerate (coincident, collinear).
      a = '{16'h0000, 16'h0000, 16'h0000};
      b = '{16'h0100, 16'h0000, 16'h0000};
      c = '{16'h0000, 16'h0100, 16'h0000};
      send_vertices(a, b, c);            // +z
      send_vertices(a, c, b);            // -z
      b = '{16'h0000, 16'h0100, 16'h0000};
      c = '{16'h0000, 16'h0000, 16'h0100};
      send_vertices(a, b, c);            // +x
      send_vertices(a, c, b);
      b = '{16'h0000, 16'h0000, 16'h0100};
      c = '{16'h0100, 16'h0000, 16'h0000};
      send_vertices(a, b, c);            // +y
      send_vertices(a, c, b);
      send_vertices(a, a, a);            // coincident vertices
      b = '{16'h0100, 16'h0200, 16'h0300};
      c = '{16'h0200, 16'h0400, 16'h0600};
      send_vertices(a, b, c);            // collinear
      a = '{16'h8000, 16'h8000, 16'h8000};
      b = '{16'h7fff, 16'h8000, 16'h8000};
      c = '{16'h8000, 16'h7fff, 16'h8000};
      send_vertices(a, b, c);            // largest edges
      b = '{16'h7fff, 16'h7fff, 16'h8000};
      c = '{16'h8000, 16'h8000, 16'h7fff};
      send_vertices(a, b, c);
      a = '{16'h7fff, 16'h7fff, 16'h7fff};
      send_vertices(a, a, a);
      a = '{16'h0000, 16'h0000, 16'h0000};
      b = '{16'h0001, 16'h0000, 16'h0000};
      c = '{16'h0000, 16'h0001, 16'h0001};
      send_vertices(a, b, c);            // smallest edges
      b = '{16'h0001, 16'h0001, 16'h0001};
      c = '{16'hffff, 16'h0000, 16'h0001};
      send_vertices(a, b, c);            // equal-ish components
      t = '{default: 16'hffff};
      send_triangle(t);                  // all ones, degenerate
      t = '{default: 16'h0000};
      send_triangle(t);                  // all zeros, degenerate

      // Sender pauses here until every result has come back.
      quiesce();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 63 : 0;
         recv_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 20 : 0;
         for (int n = 0; n < RANDOM_TRIANGLES / 3; n++) begin
            int spread;
            spread = $urandom_range(1) ? 32767 : $urandom_range(64, 4096);
            for (int k = 0; k < 3; k++) begin
               a[k] = rand_coord(spread);
               b[k] = rand_coord(spread);
               c[k] = rand_coord(spread);
            end
            case ($urandom_range(9))
               0: b = a;                          // coincident edge
               1: for (int k = 0; k < 3; k++)     // collinear, c = 2b - a
                     c[k] = 16'(2 * $signed(b[k]) - $signed(a[k]));
               default: ;
            endcase
            send_vertices(a, b, c);
            if (n % 50 == 49 && $urandom_range(3) == 0) begin
               req_chan.valid <= 1'b0;
               repeat ($urandom_range(30)) @(negedge clock);
            end
         end
      end

      quiesce();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
`default_nettype wire

### sim.f
design/tfn_pkg.sv
design/tfn_if.sv
design/triangle_face_normal_top.sv
tb/tfn_normal_checker.sv
tb/tb_triangle_face_normal_top.sv
